>>> rtl/core/adc_kp_pkg.sv
`default_nettype none

package adc_kp_pkg;

  // Fixed field widths of the register file and the result channel.
  localparam int LEVEL_W    = 12;
  localparam int TICK_W     = 16;
  localparam int KEY_W      = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Key codes.
  localparam logic [KEY_W-1:0] KEY_UP    = 2'd0;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 2'd1;
  localparam logic [KEY_W-1:0] KEY_ENTER = 2'd2;
  localparam logic [KEY_W-1:0] KEY_BACK  = 2'd3;

  // Saturation value of the hold-time counter.
  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] UP_LEVEL_RST      = 12'd3700;
  localparam logic [LEVEL_W-1:0] DOWN_LEVEL_RST    = 12'd2776;
  localparam logic [LEVEL_W-1:0] ENTER_LEVEL_RST   = 12'd1788;
  localparam logic [LEVEL_W-1:0] BACK_LEVEL_RST    = 12'd736;
  localparam logic [LEVEL_W-1:0] MATCH_WINDOW_RST  = 12'd120;
  localparam logic [LEVEL_W-1:0] RELEASE_LEVEL_RST = 12'd4000;
  localparam logic [TICK_W-1:0]  LONG_TICKS_RST    = 16'd250;
  localparam logic [TICK_W-1:0]  SUPER_TICKS_RST   = 16'd800;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_LEVEL,
    CFG_DOWN_LEVEL,
    CFG_ENTER_LEVEL,
    CFG_BACK_LEVEL,
    CFG_MATCH_WINDOW,
    CFG_RELEASE_LEVEL,
    CFG_LONG_TICKS,
    CFG_SUPER_TICKS
  } cfg_reg_t;

  // Press tracking phases.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_LONG,
    PH_SUPER
  } press_phase_t;

  // Reported event kinds.
  typedef enum logic [KIND_W-1:0] {
    EV_SHORT,
    EV_LONG,
    EV_SUPER
  } event_kind_t;

  // Level settings used by the classifier.
  typedef struct packed {
    logic [LEVEL_W-1:0] up_lvl;
    logic [LEVEL_W-1:0] down_lvl;
    logic [LEVEL_W-1:0] enter_lvl;
    logic [LEVEL_W-1:0] back_lvl;
    logic [LEVEL_W-1:0] window;
    logic [LEVEL_W-1:0] release_lvl;
  } key_cfg_t;

  // Classifier verdict: a key was recognised, and which one.
  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
  } key_match_t;

  // Event produced by the press tracker.
  typedef struct packed {
    logic             fire;
    logic [KEY_W-1:0] key;
    event_kind_t      kind;
  } press_event_t;

endpackage

`default_nettype wire

>>> rtl/core/adc_kp_in_if.sv
`default_nettype none

// Sample channel: one transfer per sample tick.
interface adc_kp_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   self_test_ok;

  modport source (output valid, output sample, output self_test_ok, input ready);
  modport sink   (input valid, input sample, input self_test_ok, output ready);
endinterface

`default_nettype wire

>>> rtl/core/adc_kp_out_if.sv
`default_nettype none

// Key event channel.
interface adc_kp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_index;
  logic [1:0] event_kind;

  modport source (output valid, output key_index, output event_kind, input ready);
  modport sink   (input valid, input key_index, input event_kind, output ready);
endinterface

`default_nettype wire

>>> rtl/core/adc_kp_median.sv
`default_nettype none

// Median of a full window by ranking: all pairs compared, ties broken
// by position; the middle rank entry, or floor mean of two if N even.
module adc_kp_median #(
  parameter int N  = 5,
  parameter int SB = 12
) (
  input  logic [SB-1:0] win [N],
  output logic [SB-1:0] median
);

  localparam int RW = $clog2(N);

  logic [RW-1:0] rank [N];
  logic [SB-1:0] hi;

  // Rank of each entry: how many entries sort before it.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + RW'(1);
          end
        end
      end
    end
  end

  // Upper middle entry; ranks form a permutation so exactly one matches.
  always_comb begin
    hi = '0;
    for (int i = 0; i < N; i++) begin
      if (rank[i] == RW'(N / 2)) begin
        hi = hi | win[i];
      end
    end
  end

  if ((N % 2) == 1) begin : g_odd
    assign median = hi;
  end else begin : g_even
    logic [SB-1:0] lo;
    logic [SB:0]   pair_sum;

    // Lower middle entry, then the floor of the mean of the two.
    always_comb begin
      lo = '0;
      for (int i = 0; i < N; i++) begin
        if (rank[i] == RW'(N / 2 - 1)) begin
          lo = lo | win[i];
        end
      end
    end

    assign pair_sum = {1'b0, lo} + {1'b0, hi};
    assign median   = pair_sum[SB:1];
  end

endmodule

`default_nettype wire

>>> rtl/core/adc_kp_classify.sv
`default_nettype none

// Maps a median reading to a key, or to no key.
module adc_kp_classify
  import adc_kp_pkg::*;
#(
  parameter int SB = 12
) (
  input  logic [SB-1:0] median,
  input  key_cfg_t      cfg,
  output key_match_t    match
);

  // One spare bit so that level plus window and reading plus window never wrap.
  localparam int CW = ((SB > LEVEL_W) ? SB : LEVEL_W) + 1;

  logic [CW-1:0] mx;
  logic [CW-1:0] wx;
  logic [CW-1:0] lvl [4];
  logic [3:0]    in_range;

  assign mx     = CW'(median);
  assign wx     = CW'(cfg.window);
  assign lvl[0] = CW'(cfg.up_lvl);
  assign lvl[1] = CW'(cfg.down_lvl);
  assign lvl[2] = CW'(cfg.enter_lvl);
  assign lvl[3] = CW'(cfg.back_lvl);

  // level - window <= m is tested as level <= m + window.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_range[k] = ((mx + wx) >= lvl[k]) && (mx <= (lvl[k] + wx));
    end
  end

  // Lowest matching key wins; above the release level nothing matches.
  always_comb begin
    match = '{hit: 1'b0, key: KEY_UP};
    if (mx <= CW'(cfg.release_lvl)) begin
      for (int k = 3; k >= 0; k--) begin
        if (in_range[k]) begin
          match.hit = 1'b1;
          match.key = KEY_W'(k);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/adc_kp_press_fsm.sv
`default_nettype none

// Press tracker: hold-time counter and idle / pressed / long / super-long
// phases. The event for a decision is produced combinationally.
module adc_kp_press_fsm
  import adc_kp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              decide,
  input  key_match_t        km,
  input  logic [TICK_W-1:0] long_ticks,
  input  logic [TICK_W-1:0] super_ticks,
  output press_event_t      evt
);

  press_phase_t      phase_r, phase_nxt;
  logic [KEY_W-1:0]  held_r, held_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0] elapsed_inc;
  logic              same;

  // Tracker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      held_r    <= '0;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // The counter advances on every tick before the decision looks at it.
  assign elapsed_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + TICK_W'(1);
  assign same        = km.hit && (km.key == held_r);

  // Phase transitions and event generation.
  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    elapsed_nxt = tick ? elapsed_inc : elapsed_r;
    evt         = '{fire: 1'b0, key: held_r, kind: EV_SHORT};
    if (decide) begin
      case (phase_r)
        PH_IDLE: begin
          if (km.hit) begin
            phase_nxt   = PH_PRESSED;
            held_nxt    = km.key;
            elapsed_nxt = '0;
          end
        end
        PH_PRESSED: begin
          if (!same) begin
            evt.fire  = 1'b1;
            phase_nxt = PH_IDLE;
            held_nxt  = KEY_UP;
          end else if (elapsed_inc >= long_ticks) begin
            evt.fire  = 1'b1;
            evt.kind  = EV_LONG;
            phase_nxt = PH_LONG;
          end
        end
        PH_LONG: begin
          if (!same) begin
            phase_nxt = PH_IDLE;
            held_nxt  = KEY_UP;
          end else if ((held_r == KEY_UP) && (elapsed_inc >= super_ticks)) begin
            evt.fire  = 1'b1;
            evt.kind  = EV_SUPER;
            phase_nxt = PH_SUPER;
          end
        end
        default: begin
          if (!same) begin
            phase_nxt = PH_IDLE;
            held_nxt  = KEY_UP;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/adc_ladder_key_press_classifier_core.sv
`default_nettype none

// Channel   Role    Payload                         Handshake
// in_chan   sink    sample, self_test_ok            valid / ready
// out_chan  source  key_index, event_kind           valid / ready
// cfg_*     write   cfg_index, cfg_wdata            cfg_we, no wait
//
// One sample per cycle sustained: a transfer lands in the input register and
// is processed from there into the output register, which presents the key event.
// Reset is synchronous and active low; it restores the register defaults,
// empties the window and returns the tracker to idle. There is no clearing pass.
// While the output register holds an event and out_chan.ready is low, the waiting
// sample is held and the input stalls, whether or not that sample makes an event.
module adc_ladder_key_press_classifier_core
  import adc_kp_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 5,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  adc_kp_in_if.sink             in_chan,
  adc_kp_out_if.source          out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int N  = WINDOW_SAMPLES;
  localparam int SB = SAMPLE_BITS;
  localparam int FW = $clog2(N);

  // Configuration registers.
  key_cfg_t          kcfg_r;
  logic [TICK_W-1:0] long_ticks_r;
  logic [TICK_W-1:0] super_ticks_r;

  // Input register.
  logic              in_valid_r;
  logic [SB-1:0]     in_sample_r;
  logic              in_ok_r;

  // Window store and fill count; the last entry is the sample being processed.
  logic [SB-1:0]     win_r [N-1];
  logic [FW-1:0]     fill_r;
  logic [SB-1:0]     win_view [N];

  // Output register.
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  event_kind_t       out_kind_r;

  logic              advance;
  logic              full_now;
  logic [SB-1:0]     median;
  key_match_t        km;
  press_event_t      evt;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kcfg_r.up_lvl      <= UP_LEVEL_RST;
      kcfg_r.down_lvl    <= DOWN_LEVEL_RST;
      kcfg_r.enter_lvl   <= ENTER_LEVEL_RST;
      kcfg_r.back_lvl    <= BACK_LEVEL_RST;
      kcfg_r.window      <= MATCH_WINDOW_RST;
      kcfg_r.release_lvl <= RELEASE_LEVEL_RST;
      long_ticks_r       <= LONG_TICKS_RST;
      super_ticks_r      <= SUPER_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_UP_LEVEL:      kcfg_r.up_lvl      <= cfg_wdata[LEVEL_W-1:0];
        CFG_DOWN_LEVEL:    kcfg_r.down_lvl    <= cfg_wdata[LEVEL_W-1:0];
        CFG_ENTER_LEVEL:   kcfg_r.enter_lvl   <= cfg_wdata[LEVEL_W-1:0];
        CFG_BACK_LEVEL:    kcfg_r.back_lvl    <= cfg_wdata[LEVEL_W-1:0];
        CFG_MATCH_WINDOW:  kcfg_r.window      <= cfg_wdata[LEVEL_W-1:0];
        CFG_RELEASE_LEVEL: kcfg_r.release_lvl <= cfg_wdata[LEVEL_W-1:0];
        CFG_LONG_TICKS:    long_ticks_r       <= cfg_wdata[TICK_W-1:0];
        CFG_SUPER_TICKS:   super_ticks_r      <= cfg_wdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held item moves on unless a pending event is not being taken.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_sample_r <= in_chan.sample;
      in_ok_r     <= in_chan.self_test_ok;
    end
  end

  // Window filling: a sample that completes the window is not stored.
  assign full_now = in_ok_r && (fill_r == FW'(N - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (advance && in_ok_r) begin
      fill_r <= full_now ? '0 : fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N - 1; i++) begin
      if (advance && in_ok_r && (fill_r == FW'(i))) begin
        win_r[i] <= in_sample_r;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N - 1; i++) begin
      win_view[i] = win_r[i];
    end
    win_view[N-1] = in_sample_r;
  end

  adc_kp_median #(
    .N  (N),
    .SB (SB)
  ) u_median (
    .win    (win_view),
    .median (median)
  );

  adc_kp_classify #(
    .SB (SB)
  ) u_classify (
    .median (median),
    .cfg    (kcfg_r),
    .match  (km)
  );

  adc_kp_press_fsm u_press (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (advance),
    .decide      (advance && full_now),
    .km          (km),
    .long_ticks  (long_ticks_r),
    .super_ticks (super_ticks_r),
    .evt         (evt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && full_now && evt.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && full_now && evt.fire) begin
      out_key_r  <= evt.key;
      out_kind_r <= evt.kind;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.key_index  = out_key_r;
  assign out_chan.event_kind = out_kind_r;

endmodule

`default_nettype wire

>>> rtl/core/adc_kp_checker.sv
`default_nettype none

// Port-level checks on the key event channel.
module adc_kp_checker
  import adc_kp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KEY_W-1:0] out_key,
  input logic [1:0]       out_kind
);

  // No event is presented in the cycle after a reset edge.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event valid after reset");

  // A stalled event stays offered.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  // A stalled event keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_key) && $stable(out_kind))
    else $error("event payload changed while stalled");

  // Only short, long and super-long events exist.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == EV_SHORT) || (out_kind == EV_LONG) ||
                  (out_kind == EV_SUPER))
    else $error("illegal event kind");

  // Super-long presses are reported for the up key alone.
  a_super_up_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == EV_SUPER) |-> (out_key == KEY_UP))
    else $error("super-long press on a key other than up");

endmodule

bind adc_ladder_key_press_classifier_core adc_kp_checker u_adc_kp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_key   (out_chan.key_index),
  .out_kind  (out_chan.event_kind)
);

`default_nettype wire

>>> tb/testbench.sv
module testbench;
  import adc_kp_pkg::*;

  localparam int WIN            = 5;
  localparam int NO_KEY         = -1;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int OUTAGE_TICKS   = 100;

  typedef enum int {
    MODE_NONE,
    MODE_TX,
    MODE_RX,
    MODE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [LEVEL_W-1:0] sample;
    logic               ok;
  } sample_item_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    event_kind_t      kind;
  } key_event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  adc_kp_in_if #(.SAMPLE_BITS(LEVEL_W)) in_chan();
  adc_kp_out_if                         out_chan();

  adc_ladder_key_press_classifier_core #(
    .WINDOW_SAMPLES(WIN),
    .SAMPLE_BITS(LEVEL_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Samples waiting to be offered and key events the block still owes us.
  sample_item_t pending_samples[$];
  key_event_t   key_events[$];

  idle_mode_t idle_mode;
  int         fail_count;
  int         gen_count;
  int         hold_left;
  bit         hold_done;
  int         quiet_cycles;

  // Shadow copy of the register file.
  logic [LEVEL_W-1:0] key_lvl [4];
  logic [LEVEL_W-1:0] match_w;
  logic [LEVEL_W-1:0] release_lvl;
  logic [TICK_W-1:0]  long_ticks;
  logic [TICK_W-1:0]  super_ticks;

  // Shadow copy of the classifier and press tracker state.
  logic [LEVEL_W-1:0] win_buf [WIN];
  int                 win_count;
  press_phase_t       trk_phase;
  logic [KEY_W-1:0]   trk_key;
  logic [TICK_W-1:0]  hold_ticks;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Key whose window holds the median, or none.
  function automatic int match_key(logic [LEVEL_W-1:0] med);
    int m;
    int w;
    int k;
    m = int'(med);
    w = int'(match_w);
    if (med > release_lvl) return NO_KEY;
    for (k = 0; k < 4; k++) begin
      if (m >= int'(key_lvl[k]) - w && m <= int'(key_lvl[k]) + w) return k;
    end
    return NO_KEY;
  endfunction

  // Advance the shadow state by one sample tick and queue any key event.
  task automatic classify_tick(logic [LEVEL_W-1:0] smp, logic ok);
    logic [LEVEL_W-1:0] sorted [WIN];
    logic [LEVEL_W-1:0] v;
    int                 i;
    int                 j;
    int                 key;
    bit                 same;
    if (hold_ticks != TICK_MAX) hold_ticks++;
    if (!ok) return;
    win_buf[win_count] = smp;
    win_count++;
    if (win_count < WIN) return;
    win_count = 0;
    for (i = 0; i < WIN; i++) begin
      v = win_buf[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    key  = match_key(sorted[WIN/2]);
    same = (key != NO_KEY) && (key == int'(trk_key));
    case (trk_phase)
      PH_IDLE: begin
        if (key != NO_KEY) begin
          trk_phase  = PH_PRESSED;
          trk_key    = key[KEY_W-1:0];
          hold_ticks = '0;
        end
      end
      PH_PRESSED: begin
        if (!same) begin
          key_events.push_back('{key: trk_key, kind: EV_SHORT});
          trk_phase = PH_IDLE;
          trk_key   = KEY_UP;
        end else if (hold_ticks >= long_ticks) begin
          key_events.push_back('{key: trk_key, kind: EV_LONG});
          trk_phase = PH_LONG;
        end
      end
      PH_LONG: begin
        if (!same) begin
          trk_phase = PH_IDLE;
          trk_key   = KEY_UP;
        end else if (trk_key == KEY_UP && hold_ticks >= super_ticks) begin
          key_events.push_back('{key: KEY_UP, kind: EV_SUPER});
          trk_phase = PH_SUPER;
        end
      end
      default: begin
        if (!same) begin
          trk_phase = PH_IDLE;
          trk_key   = KEY_UP;
        end
      end
    endcase
  endtask

  // Driver: offers queued samples and updates the prediction on each transfer.
  always @(posedge clk) begin
    sample_item_t nxt;
    int           gap_pct;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        classify_tick(in_chan.sample, in_chan.self_test_ok);
      end
      gap_pct = (idle_mode == MODE_TX) ? 72 : (idle_mode == MODE_BOTH) ? 11 : 0;
      if (!(in_chan.valid && !in_chan.ready)) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = pending_samples.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.sample       <= nxt.sample;
          in_chan.self_test_ok <= nxt.ok;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each event transfer against the oldest prediction.
  always @(posedge clk) begin
    key_event_t want;
    int         stall_pct;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (key_events.size() == 0) begin
          $error("unexpected key event: key_index %0d, event_kind %0d",
                 out_chan.key_index, out_chan.event_kind);
          fail_count++;
        end else begin
          want = key_events.pop_front();
          if (out_chan.key_index !== want.key) begin
            $error("key_index: expected %0d, actual %0d", want.key, out_chan.key_index);
            fail_count++;
          end
          if (out_chan.event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, out_chan.event_kind);
            fail_count++;
          end
        end
      end
      // One long hold-off while the sender keeps going, so the block backs up.
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && idle_mode == MODE_RX && out_chan.valid) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      stall_pct = (idle_mode == MODE_RX) ? 72 : (idle_mode == MODE_BOTH) ? 11 : 0;
      out_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic [LEVEL_W-1:0] smp, logic ok);
    pending_samples.push_back('{sample: smp, ok: ok});
    gen_count++;
  endtask

  task automatic push_flat_window(logic [LEVEL_W-1:0] smp);
    int i;
    for (i = 0; i < WIN; i++) push_item(smp, 1'b1);
  endtask

  // Reading inside the match window of key k, sometimes right on its edge,
  // sometimes a stray value that the median should reject.
  function automatic logic [LEVEL_W-1:0] key_sample(int k);
    int lv;
    int w;
    int v;
    lv = int'(key_lvl[k]);
    w  = int'(match_w);
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, 4095);
      1:       v = $urandom_range(0, 1) ? lv - w : lv + w;
      default: v = lv - w + int'($urandom_range(0, 2 * w));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[LEVEL_W-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] release_sample();
    if (release_lvl == 12'hFFF) return LEVEL_W'($urandom_range(0, 4095));
    return LEVEL_W'($urandom_range(int'(release_lvl) + 1, 4095));
  endfunction

  // Five accepted samples for key k (or released keys when k is negative),
  // with the odd self-test failure mixed in.
  task automatic push_window(int k);
    int i;
    i = 0;
    while (i < WIN) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(LEVEL_W'($urandom_range(0, 4095)), 1'b0);
      end else begin
        push_item((k < 0) ? release_sample() : key_sample(k), 1'b1);
        i++;
      end
    end
  endtask

  // Number of windows to hold a key: short, past the long threshold, or past
  // the super-long threshold for the up key.
  function automatic int hold_windows(int k);
    int r;
    r = $urandom_range(0, 99);
    if (k == 0 && r >= 85 && super_ticks / WIN < 60) return super_ticks / WIN + $urandom_range(1, 4);
    if (r >= 50 && long_ticks / WIN < 60) return long_ticks / WIN + $urandom_range(1, 4);
    return $urandom_range(1, 3);
  endfunction

  // Press, key change and noise sequences until n items have been queued.
  task automatic random_traffic(int n);
    int stop_at;
    int r;
    int a;
    int b;
    int i;
    int cnt;
    stop_at = gen_count + n;
    while (gen_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        a   = $urandom_range(0, 3);
        cnt = hold_windows(a);
        for (i = 0; i < cnt; i++) push_window(a);
        cnt = $urandom_range(1, 2);
        for (i = 0; i < cnt; i++) push_window(NO_KEY);
      end else if (r < 80) begin
        a   = $urandom_range(0, 3);
        b   = (a + $urandom_range(1, 3)) % 4;
        cnt = $urandom_range(1, 4);
        for (i = 0; i < cnt; i++) push_window(a);
        cnt = $urandom_range(1, 4);
        for (i = 0; i < cnt; i++) push_window(b);
        push_window(NO_KEY);
      end else begin
        cnt = $urandom_range(1, 10);
        for (i = 0; i < cnt; i++) begin
          push_item(LEVEL_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // Waits until every sample is transferred and every event checked.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_chan.valid || key_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_UP_LEVEL:      key_lvl[KEY_UP]    = val[LEVEL_W-1:0];
      CFG_DOWN_LEVEL:    key_lvl[KEY_DOWN]  = val[LEVEL_W-1:0];
      CFG_ENTER_LEVEL:   key_lvl[KEY_ENTER] = val[LEVEL_W-1:0];
      CFG_BACK_LEVEL:    key_lvl[KEY_BACK]  = val[LEVEL_W-1:0];
      CFG_MATCH_WINDOW:  match_w            = val[LEVEL_W-1:0];
      CFG_RELEASE_LEVEL: release_lvl        = val[LEVEL_W-1:0];
      CFG_LONG_TICKS:    long_ticks         = val;
      default:           super_ticks        = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int up, int down, int enter, int back, int w, int rel,
                           int long_t, int super_t);
    write_reg(CFG_UP_LEVEL, CFG_DATA_W'(up));
    write_reg(CFG_DOWN_LEVEL, CFG_DATA_W'(down));
    write_reg(CFG_ENTER_LEVEL, CFG_DATA_W'(enter));
    write_reg(CFG_BACK_LEVEL, CFG_DATA_W'(back));
    write_reg(CFG_MATCH_WINDOW, CFG_DATA_W'(w));
    write_reg(CFG_RELEASE_LEVEL, CFG_DATA_W'(rel));
    write_reg(CFG_LONG_TICKS, CFG_DATA_W'(long_t));
    write_reg(CFG_SUPER_TICKS, CFG_DATA_W'(super_t));
  endtask

  // Stimulus sequencing.
  initial begin
    int i;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_chan.valid        = 1'b0;
    in_chan.sample       = '0;
    in_chan.self_test_ok = 1'b0;
    out_chan.ready       = 1'b0;
    idle_mode            = MODE_NONE;
    fail_count           = 0;
    gen_count            = 0;
    hold_left            = 0;
    hold_done            = 1'b0;
    quiet_cycles         = 0;
    key_lvl[KEY_UP]      = UP_LEVEL_RST;
    key_lvl[KEY_DOWN]    = DOWN_LEVEL_RST;
    key_lvl[KEY_ENTER]   = ENTER_LEVEL_RST;
    key_lvl[KEY_BACK]    = BACK_LEVEL_RST;
    match_w              = MATCH_WINDOW_RST;
    release_lvl          = RELEASE_LEVEL_RST;
    long_ticks           = LONG_TICKS_RST;
    super_ticks          = SUPER_TICKS_RST;
    win_count            = 0;
    trk_phase            = PH_IDLE;
    trk_key              = KEY_UP;
    hold_ticks           = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks at the reset settings: an ignored sample, the sample
    // extremes, the inclusive window edges and a change of key.
    push_item(12'hFFF, 1'b0);
    push_item(12'h000, 1'b1);
    push_item(12'h000, 1'b1);
    push_item(12'h000, 1'b1);
    push_item(12'hFFF, 1'b1);
    push_item(12'hFFF, 1'b1);
    push_flat_window(12'd3820);
    push_flat_window(12'd2656);
    push_flat_window(12'd2656);
    push_flat_window(12'd4001);
    wait_drained();

    // Hold the up key across a self-test outage: time keeps counting while
    // samples are ignored, so the next windows reach the long and super-long
    // thresholds.
    write_reg(CFG_LONG_TICKS, 16'd40);
    write_reg(CFG_SUPER_TICKS, 16'd90);
    push_flat_window(UP_LEVEL_RST);
    for (i = 0; i < OUTAGE_TICKS; i++) push_item(LEVEL_W'($urandom_range(0, 4095)), 1'b0);
    push_flat_window(UP_LEVEL_RST);
    push_flat_window(UP_LEVEL_RST);
    push_flat_window(12'hFFF);
    wait_drained();

    // Zero hold thresholds, no idling.
    write_all(UP_LEVEL_RST, DOWN_LEVEL_RST, ENTER_LEVEL_RST, BACK_LEVEL_RST,
              MATCH_WINDOW_RST, RELEASE_LEVEL_RST, 0, 0);
    random_traffic(350);
    wait_drained();

    // Levels at the range ends, sender idling.
    idle_mode = MODE_TX;
    write_all(4095, 3000, 1500, 0, 300, 4095, 1, 65535);
    random_traffic(350);
    wait_drained();

    // Random levels, receiver stalling with one long hold-off.
    idle_mode = MODE_RX;
    write_all($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 4095), $urandom_range(20, 400), $urandom_range(2000, 4095),
              $urandom_range(2, 40), $urandom_range(10, 120));
    random_traffic(350);
    wait_drained();

    // Widest match window: anything below the release level is the up key.
    idle_mode = MODE_BOTH;
    write_all(UP_LEVEL_RST, DOWN_LEVEL_RST, ENTER_LEVEL_RST, BACK_LEVEL_RST,
              4095, 2000, 5, 20);
    random_traffic(300);
    wait_drained();

    // Fully random settings, no idling.
    idle_mode = MODE_NONE;
    write_all($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 4095),
              $urandom_range(1, 30), $urandom_range(1, 60));
    random_traffic(350);
    wait_drained();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
